// File: rtl/ptx_pkg.sv
// ----------------------------------------------------------------------------
// ptx_pkg
// Shared types and constants for the 4x4 point transform pipeline.
// ----------------------------------------------------------------------------
package ptx_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int VAL_W     = 32;
  localparam int COEF_W    = 64;

  // Sideband that rides next to the divider stages
  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] rx;
    logic signed [VAL_W-1:0] ry;
    logic signed [VAL_W-1:0] rz;
    logic signed [VAL_W-1:0] rw;
    logic                    nx;
    logic                    ny;
    logic                    nz;
    logic                    sat;
    logic                    dz;
  } side_t;

endpackage

// File: rtl/ptx_dot_row.sv
// ----------------------------------------------------------------------------
// ptx_dot_row
// Two-stage exact dot product of one matrix row, floored and saturated.
// ----------------------------------------------------------------------------
module ptx_dot_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [ptx_pkg::VAL_W-1:0] coef [4],
  input  logic signed [ptx_pkg::VAL_W-1:0] vec  [4],
  output logic signed [ptx_pkg::VAL_W-1:0] res,
  output logic                           sat
);
  import ptx_pkg::*;

  localparam logic signed [65:0] MAXV = 66'sd2147483647;
  localparam logic signed [65:0] MINV = -66'sd2147483648;

  logic signed [63:0] prod [4];
  logic signed [65:0] sum;
  logic signed [65:0] flr;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod[c] <= coef[c] * vec[c];
      end
    end
  end

  always_comb begin
    sum = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]) + 66'(prod[3]);
    flr = sum >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flr > MAXV) begin
        res <= 32'sh7FFFFFFF;
        sat <= 1'b1;
      end else if (flr < MINV) begin
        res <= 32'sh80000000;
        sat <= 1'b1;
      end else begin
        res <= flr[31:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ptx_divider.sv
// ----------------------------------------------------------------------------
// ptx_divider
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ptx_divider #(
  parameter int NW = 48
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [NW-1:0]                 num,
  input  logic [ptx_pkg::VAL_W-1:0]     den,
  output logic [NW-1:0]                 quo
);
  import ptx_pkg::*;

  logic [32:0]   rem_s [1:NW];
  logic [NW-1:0] num_s [1:NW];
  logic [NW-1:0] quo_s [1:NW];
  logic [31:0]   den_s [1:NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [32:0]   r_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [31:0]   d_in;
    logic [32:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = rem_s[i];
      assign n_in = num_s[i];
      assign q_in = quo_s[i];
      assign d_in = den_s[i];
    end

    assign trial = {r_in[31:0], n_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? (trial - {1'b0, d_in}) : trial;
        num_s[i+1] <= n_in << 1;
        quo_s[i+1] <= {q_in[NW-2:0], ge};
        den_s[i+1] <= d_in;
      end
    end
  end

  assign quo = quo_s[NW];

endmodule

// File: rtl/point_transform_4x4_unit.sv
// ----------------------------------------------------------------------------
// point_transform_4x4_unit
// Homogeneous 4x4 vertex transform with perspective divide when mode is low.
// ----------------------------------------------------------------------------
// Accepts one vector per cycle while in_ready is high and returns one
// result per vector, in order, after two stages of multiply and sum for
// the four dot products, one stage of divide setup, one restoring-divider
// stage per quotient bit (32 + FRAC_BITS of them), and the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so in_ready follows out_ready. Matrix writes land
// in the cycle after the write and must be done while the pipeline is empty.
module point_transform_4x4_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptx_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [ptx_pkg::VAL_W-1:0]  in_x,
  input  logic signed [ptx_pkg::VAL_W-1:0]  in_y,
  input  logic signed [ptx_pkg::VAL_W-1:0]  in_z,
  input  logic signed [ptx_pkg::VAL_W-1:0]  in_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ptx_pkg::VAL_W-1:0]  out_x,
  output logic signed [ptx_pkg::VAL_W-1:0]  out_y,
  output logic signed [ptx_pkg::VAL_W-1:0]  out_z,
  output logic signed [ptx_pkg::VAL_W-1:0]  out_w,
  output logic                              saturated,
  output logic                              divide_by_zero
);
  import ptx_pkg::*;

  localparam int NW    = VAL_W + FRAC_BITS;
  localparam int DEPTH = 3 + NW;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = 64'(1) << (FRAC_BITS + 32);
  localparam logic signed [VAL_W-1:0] Q_ONE = VAL_W'(1) << FRAC_BITS;

  logic [COEF_W-1:0] coef_reg [NUM_REGS];
  logic              en;
  logic [DEPTH-1:0]  vld;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_reg[i] <= '0;
      end
      coef_reg[0] <= ONE_LO;
      coef_reg[2] <= ONE_HI;
      coef_reg[5] <= ONE_LO;
      coef_reg[7] <= ONE_HI;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coef_reg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[DEPTH-2:0], in_valid};
      out_valid <= vld[DEPTH-1];
    end
  end

  // Dot products
  logic signed [VAL_W-1:0] vec [4];
  logic signed [VAL_W-1:0] row_res [4];
  logic                    row_sat [4];
  logic                    mode_d1, mode_d2;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = mode ? in_w : Q_ONE;

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [VAL_W-1:0] coef [4];
    assign coef[0] = coef_reg[2*r][31:0];
    assign coef[1] = coef_reg[2*r][63:32];
    assign coef[2] = coef_reg[2*r+1][31:0];
    assign coef[3] = coef_reg[2*r+1][63:32];

    ptx_dot_row #(.FRAC_BITS(FRAC_BITS)) u_row (
      .clk  (clk),
      .en   (en),
      .coef (coef),
      .vec  (vec),
      .res  (row_res[r]),
      .sat  (row_sat[r])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_d1 <= mode;
      mode_d2 <= mode_d1;
    end
  end

  // Divide setup: magnitudes and quotient signs
  function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v);
    mag = v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

  side_t             side [0:NW];
  logic [NW-1:0]     nmag [3];
  logic [VAL_W-1:0]  dmag;
  logic [NW-1:0]     quo  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].mode <= mode_d2;
      side[0].rx   <= row_res[0];
      side[0].ry   <= row_res[1];
      side[0].rz   <= row_res[2];
      side[0].rw   <= row_res[3];
      side[0].nx   <= row_res[0][VAL_W-1] ^ row_res[3][VAL_W-1];
      side[0].ny   <= row_res[1][VAL_W-1] ^ row_res[3][VAL_W-1];
      side[0].nz   <= row_res[2][VAL_W-1] ^ row_res[3][VAL_W-1];
      side[0].sat  <= row_sat[0] | row_sat[1] | row_sat[2] | row_sat[3];
      side[0].dz   <= !mode_d2 && (row_res[3] == '0);
      for (int k = 0; k < 3; k++) begin
        nmag[k] <= NW'(mag(row_res[k])) << FRAC_BITS;
      end
      dmag <= mag(row_res[3]);
      for (int s = 0; s < NW; s++) begin
        side[s+1] <= side[s];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    ptx_divider #(.NW(NW)) u_div (
      .clk (clk),
      .en  (en),
      .num (nmag[k]),
      .den (dmag),
      .quo (quo[k])
    );
  end

  // Sign and clip the quotients
  logic signed [VAL_W-1:0] qv [3];
  logic                    qs [3];
  logic                    neg [3];
  side_t                   fin;

  assign fin    = side[NW];
  assign neg[0] = fin.nx;
  assign neg[1] = fin.ny;
  assign neg[2] = fin.nz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (neg[k]) begin
        qs[k] = (quo[k][NW-1:VAL_W-1] != '0) && (quo[k][VAL_W-2:0] != '0 ||
                quo[k][NW-1:VAL_W] != '0);
        qv[k] = qs[k] ? 32'sh80000000 : VAL_W'(~quo[k] + 1'b1);
      end else begin
        qs[k] = quo[k][NW-1:VAL_W-1] != '0;
        qv[k] = qs[k] ? 32'sh7FFFFFFF : quo[k][VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w          <= fin.rw;
      divide_by_zero <= fin.dz;
      if (fin.mode) begin
        out_x     <= fin.rx;
        out_y     <= fin.ry;
        out_z     <= fin.rz;
        saturated <= fin.sat;
      end else if (fin.dz) begin
        out_x     <= '0;
        out_y     <= '0;
        out_z     <= '0;
        saturated <= fin.sat;
      end else begin
        out_x     <= qv[0];
        out_y     <= qv[1];
        out_z     <= qv[2];
        saturated <= fin.sat | qs[0] | qs[1] | qs[2];
      end
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> out_w == '0 && out_x == '0 && out_y == '0 &&
    out_z == '0)
    else $error("zero w result not cleared");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("pipeline enable mismatch");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(saturated))
    else $error("stalled result changed");

endmodule
